// ===== hw/rtl/arpicmp_pkg.sv =====
// arpicmp_pkg: shared types, constants and byte rewrite helpers for the
// arp/icmp echo responder. depends on nothing.
package arpicmp_pkg;

   localparam int Ports     = 2;
   localparam int HoldBytes = 74;
   localparam int MaxWords  = (HoldBytes - 14) / 4;
   localparam int AddrW     = $clog2(HoldBytes);

   typedef enum logic [1:0] {
      CLS_UNKNOWN = 2'd0,
      CLS_ARP     = 2'd1,
      CLS_IPV4    = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      CSR_MAC0 = 2'd0,
      CSR_MAC1 = 2'd1,
      CSR_IP0  = 2'd2,
      CSR_IP1  = 2'd3
   } csr_type;

   localparam logic [7:0] EthTypeHi  = 8'h08;
   localparam logic [7:0] EthTypeArp = 8'h06;
   localparam logic [7:0] EthTypeIp  = 8'h00;
   localparam logic [7:0] ProtoIcmp  = 8'h01;
   localparam logic [7:0] IcmpEchoReq = 8'h08;
   localparam logic [7:0] ArpOpReply = 8'h02;
   localparam logic [7:0] IcmpEchoRep = 8'h00;

   // pick byte k (0 = first on the wire) of a mac address
   function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [7:0] k);
      logic [7:0] r;
      begin
         case (k)
            8'd0: r = m[47:40];
            8'd1: r = m[39:32];
            8'd2: r = m[31:24];
            8'd3: r = m[23:16];
            8'd4: r = m[15:8];
            default: r = m[7:0];
         endcase
         return r;
      end
   endfunction

   // header store address that supplies output byte i
   function automatic logic [AddrW-1:0] hold_addr(input logic [7:0] i, input logic is_arp,
                                                  input logic swap);
      logic [7:0] a;
      begin
         a = i;
         if (is_arp) begin
            if (i < 8'd6) a = i + 8'd6;
            else if (i >= 8'd28 && i < 8'd32) a = i + 8'd10;
         end else if (swap) begin
            if (i < 8'd6) a = i + 8'd6;
            else if (i >= 8'd26 && i < 8'd30) a = i + 8'd4;
            else if (i >= 8'd30 && i < 8'd34) a = i - 8'd4;
         end
         if (a >= 8'(HoldBytes)) a = 8'd0;
         return a[AddrW-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/arpicmp_ram.sv =====
// arpicmp_ram: generic single write, single read ram with registered read.
// depends on nothing.
module arpicmp_ram #(
   parameter int Width = 8,
   parameter int Depth = 74
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/arp_icmp_echo_responder.sv =====
// arp_icmp_echo_responder: top level, frame parsing, header hold and reply emission.
// depends on arpicmp_pkg and arpicmp_ram.
//
// usage
// - req channel carries one frame byte per transaction (req_in_byte, req_in_last,
//   req_rx_port sampled on the first byte of a frame)
// - rsp channel carries the reply frame, one byte per transaction, rsp_out_last
//   on the final byte; dropped frames give no transactions at all
// - header bytes are held in a 74 byte store until their rewritten value is
//   final, then drained in order; each held byte takes a store read (ST_READ)
//   and then an output load (ST_EMIT), and req stalls for the whole burst
// - after the header is out, payload passes through at 1 byte per cycle while
//   rsp_stall allows it, and is registered in the output register
// - a new byte is taken while the output register still holds an earlier one,
//   provided the receiver is not stalling it
// - rsp_stall freezes the output register while it holds a byte, and holds off
//   req for as long as it does
// - reset (synchronous) clears all frame tracking and the port registers;
//   the header store needs no clearing, only bytes of the current frame are read
// - csr writes are taken any cycle, but only meant while the block is idle
module arp_icmp_echo_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        req_rx_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam int AW = arpicmp_pkg::AddrW;

   // port registers
   logic [47:0] mac0_ff, mac1_ff;
   logic [31:0] ip0_ff, ip1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac0_ff <= '0;
         mac1_ff <= '0;
         ip0_ff  <= '0;
         ip1_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            arpicmp_pkg::CSR_MAC0: mac0_ff <= csr_data;
            arpicmp_pkg::CSR_MAC1: mac1_ff <= csr_data;
            arpicmp_pkg::CSR_IP0:  ip0_ff  <= csr_data[31:0];
            arpicmp_pkg::CSR_IP1:  ip1_ff  <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // frame tracking state
   arpicmp_pkg::state_type state_ff, state_in;
   arpicmp_pkg::class_type class_ff, class_in;
   logic [6:0]  pos_ff, pos_in;
   logic [3:0]  hw_ff, hw_in;
   logic [19:0] sum_ff, sum_in;
   logic [7:0]  emitted_ff, emitted_in;
   logic        port_ff, port_in;
   logic        drop_ff, drop_in;
   // captured header bytes needed outside the store
   logic [7:0]  eth12_ff, eth12_in;
   logic [23:0] tip_ff, tip_in;
   logic        icmp_ff, icmp_in;
   logic        echo_ff, echo_in;
   // burst control
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  end_ff, end_in;
   logic [6:0]  lpos_ff, lpos_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic          rsp_free;
   logic          accept;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // scratch for the accept step
   logic        drop_a, drop_b, decided;
   logic [7:0]  hend, p1, fin;
   logic [3:0]  w;
   logic [15:0] v;
   logic [19:0] t;
   logic [31:0] ip_sel;
   logic        is_arp, req_echo, swap;
   logic [47:0] mac_sel;
   logic [19:0] s1;
   logic [16:0] s2;
   logic [15:0] ck;
   logic [7:0]  rw;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != arpicmp_pkg::ST_IDLE) || !rsp_free;
   assign accept = req_valid && !req_stall;

   assign is_arp   = (class_ff == arpicmp_pkg::CLS_ARP);
   assign req_echo = icmp_ff && echo_ff;
   assign swap     = req_echo || !icmp_ff;
   assign mac_sel  = port_ff ? mac1_ff : mac0_ff;
   assign rd_addr  = arpicmp_pkg::hold_addr(idx_ff, is_arp, swap);

   // folded header checksum
   assign s1 = {4'b0, sum_ff[15:0]} + {16'b0, sum_ff[19:16]};
   assign s2 = {1'b0, s1[15:0]} + {13'b0, s1[19:16]};
   assign ck = ~s2[15:0];

   // rewritten value of held byte idx_ff
   always_comb begin
      rw = rd_data;
      if (idx_ff >= 8'(arpicmp_pkg::HoldBytes)) begin
         rw = byte_ff;
      end else if (is_arp) begin
         if (idx_ff >= 8'd6 && idx_ff < 8'd12) rw = arpicmp_pkg::mac_byte(mac_sel, idx_ff - 8'd6);
         else if (idx_ff == 8'd21) rw = arpicmp_pkg::ArpOpReply;
         else if (idx_ff >= 8'd22 && idx_ff < 8'd28)
            rw = arpicmp_pkg::mac_byte(mac_sel, idx_ff - 8'd22);
      end else begin
         if (idx_ff == 8'd24) rw = ck[15:8];
         else if (idx_ff == 8'd25) rw = ck[7:0];
         else if (swap && idx_ff >= 8'd6 && idx_ff < 8'd12)
            rw = arpicmp_pkg::mac_byte(mac_sel, idx_ff - 8'd6);
         else if (req_echo && idx_ff == 8'd34) rw = arpicmp_pkg::IcmpEchoRep;
      end
   end

   always_comb begin
      state_in     = state_ff;
      class_in     = class_ff;
      pos_in       = pos_ff;
      hw_in        = hw_ff;
      sum_in       = sum_ff;
      emitted_in   = emitted_ff;
      port_in      = port_ff;
      drop_in      = drop_ff;
      eth12_in     = eth12_ff;
      tip_in       = tip_ff;
      icmp_in      = icmp_ff;
      echo_in      = echo_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      lpos_in      = lpos_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      drop_a       = drop_ff;
      drop_b       = drop_ff;
      decided      = 1'b0;
      hend         = 8'd14 + {2'b00, hw_ff, 2'b00};
      p1           = {1'b0, pos_ff} + 8'd1;
      fin          = p1;
      w            = req_in_byte[3:0];
      v            = '0;
      t            = '0;
      ip_sel       = port_ff ? ip1_ff : ip0_ff;

      case (state_ff)
         arpicmp_pkg::ST_IDLE: begin
            if (accept) begin
               if (pos_ff == 7'd0) begin
                  port_in = req_rx_port;
                  drop_a  = (32'(req_rx_port) >= arpicmp_pkg::Ports);
                  ip_sel  = req_rx_port ? ip1_ff : ip0_ff;
               end
               drop_b = drop_a;
               // capture header bytes read outside the store
               if (pos_ff == 7'd12) eth12_in = req_in_byte;
               if (pos_ff >= 7'd38 && pos_ff <= 7'd40) tip_in = {tip_ff[15:0], req_in_byte};
               if (pos_ff == 7'd23) icmp_in = (req_in_byte == arpicmp_pkg::ProtoIcmp);
               if (pos_ff == 7'd34) echo_in = (req_in_byte == arpicmp_pkg::IcmpEchoReq);
               if (!drop_a) begin
                  wr_en = ({1'b0, pos_ff} < 8'(arpicmp_pkg::HoldBytes));
                  // ethertype decision
                  if (pos_ff == 7'd13) begin
                     if (eth12_ff == arpicmp_pkg::EthTypeHi &&
                         req_in_byte == arpicmp_pkg::EthTypeArp)
                        class_in = arpicmp_pkg::CLS_ARP;
                     else if (eth12_ff == arpicmp_pkg::EthTypeHi &&
                              req_in_byte == arpicmp_pkg::EthTypeIp)
                        class_in = arpicmp_pkg::CLS_IPV4;
                     else
                        drop_b = 1'b1;
                  end
                  // ipv4 header length and running checksum
                  if (class_in == arpicmp_pkg::CLS_IPV4 && pos_ff >= 7'd14) begin
                     if (pos_ff == 7'd14) begin
                        if (w < 4'd5) w = 4'd5;
                        if (w > 4'(arpicmp_pkg::MaxWords)) w = 4'(arpicmp_pkg::MaxWords);
                        hw_in = w;
                     end
                     hend = 8'd14 + {2'b00, hw_in, 2'b00};
                     if ({1'b0, pos_ff} < hend && pos_ff != 7'd24 && pos_ff != 7'd25) begin
                        v = pos_ff[0] ? {8'h00, req_in_byte} : {req_in_byte, 8'h00};
                        t = sum_ff + {4'b0, v};
                        sum_in = {4'b0, t[15:0]} + {16'b0, t[19:16]};
                     end
                  end
                  // arp target ip check
                  if (class_in == arpicmp_pkg::CLS_ARP && pos_ff == 7'd41) begin
                     if ({tip_ff, req_in_byte} != ip_sel) drop_b = 1'b1;
                  end
                  if (!drop_b) begin
                     decided = (class_in == arpicmp_pkg::CLS_ARP && pos_ff >= 7'd41) ||
                               (class_in == arpicmp_pkg::CLS_IPV4 && pos_ff >= 7'd34);
                     if (decided) begin
                        if (emitted_ff >= {1'b0, pos_ff}) begin
                           rsp_valid_in = 1'b1;
                           rsp_byte_in  = req_in_byte;
                           rsp_last_in  = req_in_last;
                           emitted_in   = (pos_ff < 7'd127) ? p1 : 8'd127;
                        end else begin
                           if (class_in == arpicmp_pkg::CLS_ARP || req_in_last || p1 >= hend)
                              fin = p1;
                           else
                              fin = 8'd24;
                           if (fin > emitted_ff) begin
                              // header burst from the store
                              emitted_in = fin;
                              idx_in     = emitted_ff;
                              end_in     = fin;
                              lpos_in    = pos_ff;
                              byte_in    = req_in_byte;
                              last_in    = req_in_last;
                              state_in   = arpicmp_pkg::ST_READ;
                           end
                        end
                     end
                  end
               end
               drop_in = drop_b;
               if (state_in == arpicmp_pkg::ST_IDLE && req_in_last) begin
                  pos_in     = '0;
                  class_in   = arpicmp_pkg::CLS_UNKNOWN;
                  hw_in      = '0;
                  sum_in     = '0;
                  emitted_in = '0;
                  drop_in    = 1'b0;
               end else if (!req_in_last) begin
                  pos_in = (pos_ff < 7'd127) ? pos_ff + 7'd1 : 7'd127;
               end
            end
         end
         arpicmp_pkg::ST_READ: begin
            // store read of idx_ff in flight
            state_in = arpicmp_pkg::ST_EMIT;
         end
         arpicmp_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rw;
               rsp_last_in  = last_ff && (idx_ff == {1'b0, lpos_ff});
               idx_in       = idx_ff + 8'd1;
               if (idx_ff + 8'd1 >= end_ff) begin
                  state_in = arpicmp_pkg::ST_IDLE;
                  if (last_ff) begin
                     pos_in     = '0;
                     class_in   = arpicmp_pkg::CLS_UNKNOWN;
                     hw_in      = '0;
                     sum_in     = '0;
                     emitted_in = '0;
                     drop_in    = 1'b0;
                  end
               end else begin
                  state_in = arpicmp_pkg::ST_READ;
               end
            end
         end
         default: state_in = arpicmp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arpicmp_pkg::ST_IDLE;
         class_ff     <= arpicmp_pkg::CLS_UNKNOWN;
         pos_ff       <= '0;
         hw_ff        <= '0;
         sum_ff       <= '0;
         emitted_ff   <= '0;
         port_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         class_ff     <= class_in;
         pos_ff       <= pos_in;
         hw_ff        <= hw_in;
         sum_ff       <= sum_in;
         emitted_ff   <= emitted_in;
         port_ff      <= port_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eth12_ff    <= eth12_in;
      tip_ff      <= tip_in;
      icmp_ff     <= icmp_in;
      echo_ff     <= echo_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      lpos_ff     <= lpos_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   arpicmp_ram #(
      .Width(8),
      .Depth(arpicmp_pkg::HoldBytes)
   ) u_header_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_in_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule
